### hw/rtl/im2col_patch_extract_macros.svh
// Assertion helpers for the im2col patch extractor.
// All checks run on clk and are held off while rst_n is low.
`ifndef IM2COL_PATCH_EXTRACT_MACROS_SVH
`define IM2COL_PATCH_EXTRACT_MACROS_SVH

// Same-cycle implication.
`define IM2COL_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define IM2COL_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/im2col_pkg.sv
package im2col_pkg;

  // Default sizes
  localparam int IMAGE_WORDS_DEF = 16384;
  localparam int MAX_KERNEL_DEF  = 8;

  // Item kind carried on in_tuser
  localparam logic FUNC_WRITE   = 1'b0;
  localparam logic FUNC_EXTRACT = 1'b1;

  // Result status
  localparam logic ST_OK  = 1'b0;
  localparam logic ST_ERR = 1'b1;

  // Register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_CHANNELS  = 3'd0;
  localparam logic [2:0] REG_IN_HEIGHT = 3'd1;
  localparam logic [2:0] REG_IN_WIDTH  = 3'd2;
  localparam logic [2:0] REG_KERNEL_H  = 3'd3;
  localparam logic [2:0] REG_KERNEL_W  = 3'd4;
  localparam logic [2:0] REG_PAD       = 3'd5;
  localparam logic [2:0] REG_STRIDE_H  = 3'd6;
  localparam logic [2:0] REG_STRIDE_W  = 3'd7;

  // Quotient bits of the serial divider
  localparam int DIV_BITS = 10;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIVH,
    S_DIVW,
    S_MUL,
    S_SETUP,
    S_EMIT,
    S_ERR
  } state_t;

  // Steps of the shared multiplier
  typedef enum logic [3:0] {
    MS_PLANE,
    MS_CHAN,
    MS_ROWOFS,
    MS_COLOFS,
    MS_ROWADR,
    MS_PADADR,
    MS_CROW,
    MS_AREA,
    MS_COLROW,
    MS_COLPOS,
    MS_STEP
  } mul_step_t;

endpackage

### hw/rtl/im2col_patch_extract.sv
// im2col window extractor. The block holds one multi-channel image (channel-major, then
// row, then column) in an IMAGE_WORDS x 32 on-chip store. An input transaction with
// in_tuser = 0 writes in_tdata's pixel at image_index, giving no result unless the
// address lies outside the store (one error result). A transaction with
// in_tuser = 1 extracts the kernel_h x kernel_w window of channel chan_sel at output
// position (out_row, out_col): results come out row-major, each with its column-matrix
// address, padding positions give value 0 with out_tuser[0] set, and the last one carries
// out_tlast. Bad geometry or a request outside the output grid or store gives a single
// result with out_tuser[1] set. A serial divider works out each of the two output grid
// sizes, a shared multiplier then builds the addresses, and the store delivers one window
// value per cycle as long as out_tready does not hold the output register. in_tready is low
// from acceptance of an extract until its last result is in the output register. The store
// has no reset: a window may only touch words written before. Registers sit at byte
// addresses 0x00 (channels) to 0x1C (stride_w) of the cfg port and should be written only
// while the block is idle.
`include "im2col_patch_extract_macros.svh"

module im2col_patch_extract
  import im2col_pkg::*;
#(
  parameter int IMAGE_WORDS = IMAGE_WORDS_DEF,
  parameter int MAX_KERNEL  = MAX_KERNEL_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  // image_index[13:0], pixel[45:14], chan_sel[51:46], out_row[59:52], out_col[67:60]
  input  logic [71:0] in_tdata,
  // func[0]
  input  logic        in_tuser,
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  // col_index[27:0], value[59:28]
  output logic [63:0] out_tdata,
  // is_padding[0], status[1]
  output logic [1:0]  out_tuser,
  output logic        out_tlast,
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int ADDR_W = $clog2(IMAGE_WORDS);
  localparam int KC_W   = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;

  // Input fields
  logic [13:0] in_image_index;
  logic [31:0] in_pixel;
  logic [5:0]  in_chan_sel;
  logic [7:0]  in_out_row;
  logic [7:0]  in_out_col;

  assign in_image_index = in_tdata[13:0];
  assign in_pixel       = in_tdata[45:14];
  assign in_chan_sel    = in_tdata[51:46];
  assign in_out_row     = in_tdata[59:52];
  assign in_out_col     = in_tdata[67:60];

  // Configuration registers
  logic [6:0] channels_r;
  logic [8:0] in_height_r;
  logic [8:0] in_width_r;
  logic [3:0] kernel_h_r;
  logic [3:0] kernel_w_r;
  logic [2:0] pad_r;
  logic [3:0] stride_h_r;
  logic [3:0] stride_w_r;

  logic       cfg_we;
  logic [2:0] cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      channels_r  <= 7'd1;
      in_height_r <= 9'd1;
      in_width_r  <= 9'd1;
      kernel_h_r  <= 4'd1;
      kernel_w_r  <= 4'd1;
      pad_r       <= 3'd0;
      stride_h_r  <= 4'd1;
      stride_w_r  <= 4'd1;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_CHANNELS:  channels_r  <= cfg_pwdata[6:0];
        REG_IN_HEIGHT: in_height_r <= cfg_pwdata[8:0];
        REG_IN_WIDTH:  in_width_r  <= cfg_pwdata[8:0];
        REG_KERNEL_H:  kernel_h_r  <= cfg_pwdata[3:0];
        REG_KERNEL_W:  kernel_w_r  <= cfg_pwdata[3:0];
        REG_PAD:       pad_r       <= cfg_pwdata[2:0];
        REG_STRIDE_H:  stride_h_r  <= cfg_pwdata[3:0];
        REG_STRIDE_W:  stride_w_r  <= cfg_pwdata[3:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (cfg_idx)
      REG_CHANNELS:  cfg_prdata = 32'(channels_r);
      REG_IN_HEIGHT: cfg_prdata = 32'(in_height_r);
      REG_IN_WIDTH:  cfg_prdata = 32'(in_width_r);
      REG_KERNEL_H:  cfg_prdata = 32'(kernel_h_r);
      REG_KERNEL_W:  cfg_prdata = 32'(kernel_w_r);
      REG_PAD:       cfg_prdata = 32'(pad_r);
      REG_STRIDE_H:  cfg_prdata = 32'(stride_h_r);
      REG_STRIDE_W:  cfg_prdata = 32'(stride_w_r);
      default:       cfg_prdata = 32'd0;
    endcase
  end

  // Sequencer and datapath registers
  state_t    state_r, state_nxt;
  mul_step_t mstep_r;
  logic [3:0] div_cnt_r;

  logic [5:0] chan_r;
  logic [7:0] orow_r;
  logic [7:0] ocol_r;

  logic [DIV_BITS-1:0] dq_r;
  logic [3:0]          rem_r;
  logic [9:0]          hcol_r;
  logic [9:0]          wcol_r;

  logic [17:0]       plane_r;
  logic [24:0]       cp1_r;
  logic [11:0]       rh_r;
  logic [11:0]       rw_r;
  logic [ADDR_W-1:0] rhw_r;
  logic [11:0]       padw_r;
  logic [11:0]       crow_r;
  logic [27:0]       colb_r;
  logic [19:0]       step_r;
  logic [ADDR_W-1:0] acc_r;

  // Window generator
  logic                gen_valid_r;
  logic [KC_W-1:0]     g_p_r;
  logic [KC_W-1:0]     g_j_r;
  logic signed [10:0]  g_h_r;
  logic signed [10:0]  g_w_r;
  logic signed [10:0]  w0_r;
  logic [ADDR_W-1:0]   g_row_r;
  logic [ADDR_W-1:0]   g_addr_r;
  logic [27:0]         g_col_r;

  // Stage waiting on store read data
  logic              pend_valid_r;
  logic              pend_pad_r;
  logic              pend_last_r;
  logic [27:0]       pend_col_r;
  logic [ADDR_W-1:0] pend_addr_r;

  // Output register
  logic        out_valid_r;
  logic [63:0] out_tdata_r;
  logic [1:0]  out_tuser_r;
  logic        out_tlast_r;

  // Image store
  logic [31:0]       mem [IMAGE_WORDS];
  logic [31:0]       mem_q;
  logic [ADDR_W-1:0] mem_raddr;
  logic              mem_we;

  // Control strobes
  logic in_acc;
  logic wr_bad;
  logic out_free;
  logic move;
  logic gen_go;
  logic err_load;

  // Geometry and grid checks
  logic [9:0] ph;
  logic [9:0] pw;
  logic       geo_bad;
  logic       grid_bad;

  assign ph = 10'(in_height_r) + 10'({pad_r, 1'b0});
  assign pw = 10'(in_width_r) + 10'({pad_r, 1'b0});

  assign geo_bad = (channels_r == 7'd0) || (in_height_r == 9'd0) || (in_width_r == 9'd0) ||
                   (kernel_h_r == 4'd0) || (kernel_w_r == 4'd0) ||
                   (stride_h_r == 4'd0) || (stride_w_r == 4'd0) ||
                   (32'(kernel_h_r) > 32'(MAX_KERNEL)) ||
                   (32'(kernel_w_r) > 32'(MAX_KERNEL)) ||
                   (ph < 10'(kernel_h_r)) || (pw < 10'(kernel_w_r));

  assign grid_bad = (7'(chan_r) >= channels_r) || (10'(orow_r) >= hcol_r) ||
                    (10'(ocol_r) >= wcol_r) || (32'(cp1_r) > 32'(IMAGE_WORDS));

  // Serial divider step: one quotient bit per cycle
  logic [3:0] div_den;
  logic [4:0] rem_sh;
  logic       rem_ge;
  logic [3:0] rem_nxt;
  logic [DIV_BITS-1:0] dq_nxt;

  assign div_den = (state_r == S_DIVH) ? stride_h_r : stride_w_r;
  assign rem_sh  = {rem_r, dq_r[DIV_BITS-1]};
  assign rem_ge  = rem_sh >= {1'b0, div_den};
  assign rem_nxt = rem_ge ? 4'(rem_sh - {1'b0, div_den}) : rem_sh[3:0];
  assign dq_nxt  = {dq_r[DIV_BITS-2:0], rem_ge};

  // Shared multiplier, operands picked by the step
  logic [27:0] mul_a;
  logic [17:0] mul_b;
  logic [27:0] mul_p;

  always_comb begin
    case (mstep_r)
      MS_PLANE:  begin mul_a = 28'(in_height_r);          mul_b = 18'(in_width_r); end
      MS_CHAN:   begin mul_a = 28'(chan_r) + 28'd1;       mul_b = plane_r;         end
      MS_ROWOFS: begin mul_a = 28'(orow_r);               mul_b = 18'(stride_h_r); end
      MS_COLOFS: begin mul_a = 28'(ocol_r);               mul_b = 18'(stride_w_r); end
      MS_ROWADR: begin mul_a = 28'(rh_r);                 mul_b = 18'(in_width_r); end
      MS_PADADR: begin mul_a = 28'(pad_r);                mul_b = 18'(in_width_r); end
      MS_CROW:   begin mul_a = 28'(chan_r);               mul_b = 18'(kernel_h_r); end
      MS_AREA:   begin mul_a = 28'(crow_r);               mul_b = 18'(kernel_w_r); end
      MS_COLROW: begin mul_a = 28'(crow_r);               mul_b = 18'(hcol_r);     end
      MS_COLPOS: begin mul_a = colb_r + 28'(orow_r);      mul_b = 18'(wcol_r);     end
      MS_STEP:   begin mul_a = 28'(hcol_r);               mul_b = 18'(wcol_r);     end
      default:   begin mul_a = 28'd0;                     mul_b = 18'd0;           end
    endcase
  end

  assign mul_p = 28'(mul_a * mul_b);

  // Current window position
  logic g_pad;
  logic g_last;
  logic g_row_end;

  assign g_pad = g_h_r[10] || g_w_r[10] ||
                 (g_h_r >= $signed({2'b00, in_height_r})) ||
                 (g_w_r >= $signed({2'b00, in_width_r}));
  assign g_row_end = (4'(g_j_r) == 4'(kernel_w_r - 4'd1));
  assign g_last    = g_row_end && (4'(g_p_r) == 4'(kernel_h_r - 4'd1));

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_tuser == FUNC_EXTRACT) begin
            state_nxt = S_CHECK;
          end else if (wr_bad) begin
            state_nxt = S_ERR;
          end
        end
      end
      S_CHECK: begin
        state_nxt = geo_bad ? S_ERR : S_DIVH;
      end
      S_DIVH: begin
        if (div_cnt_r == 4'(DIV_BITS - 1)) state_nxt = S_DIVW;
      end
      S_DIVW: begin
        if (div_cnt_r == 4'(DIV_BITS - 1)) state_nxt = S_MUL;
      end
      S_MUL: begin
        if (mstep_r == MS_STEP) state_nxt = S_SETUP;
      end
      S_SETUP: begin
        state_nxt = grid_bad ? S_ERR : S_EMIT;
      end
      S_EMIT: begin
        if (!gen_valid_r && (!pend_valid_r || move)) state_nxt = S_IDLE;
      end
      S_ERR: begin
        if (err_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_tready = (state_r == S_IDLE);
    in_acc    = in_tvalid && in_tready;
    wr_bad    = (in_tuser == FUNC_WRITE) && (32'(in_image_index) >= 32'(IMAGE_WORDS));
    mem_we    = in_acc && (in_tuser == FUNC_WRITE) && !wr_bad;
    out_free  = !out_valid_r || out_tready;
    move      = (state_r == S_EMIT) && pend_valid_r && out_free;
    gen_go    = (state_r == S_EMIT) && gen_valid_r && (!pend_valid_r || move);
    err_load  = (state_r == S_ERR) && out_free;
    mem_raddr = gen_go ? g_addr_r : pend_addr_r;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      mstep_r      <= MS_PLANE;
      div_cnt_r    <= 4'd0;
      gen_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (state_r == S_DIVH || state_r == S_DIVW) begin
        div_cnt_r <= (div_cnt_r == 4'(DIV_BITS - 1)) ? 4'd0 : div_cnt_r + 4'd1;
      end else begin
        div_cnt_r <= 4'd0;
      end

      if (state_r == S_MUL && mstep_r != MS_STEP) begin
        mstep_r <= mul_step_t'(mstep_r + 4'd1);
      end else begin
        mstep_r <= MS_PLANE;
      end

      if (state_r == S_SETUP && !grid_bad) begin
        gen_valid_r <= 1'b1;
      end else if (gen_go && g_last) begin
        gen_valid_r <= 1'b0;
      end

      if (gen_go) begin
        pend_valid_r <= 1'b1;
      end else if (move) begin
        pend_valid_r <= 1'b0;
      end

      if (move || err_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Item capture, divider and multiplier results
  always_ff @(posedge clk) begin
    if (in_acc) begin
      chan_r <= in_chan_sel;
      orow_r <= in_out_row;
      ocol_r <= in_out_col;
    end

    case (state_r)
      S_CHECK: begin
        dq_r  <= 10'(ph - 10'(kernel_h_r));
        rem_r <= 4'd0;
      end
      S_DIVH: begin
        if (div_cnt_r == 4'(DIV_BITS - 1)) begin
          hcol_r <= 10'(dq_nxt + 10'd1);
          dq_r   <= 10'(pw - 10'(kernel_w_r));
          rem_r  <= 4'd0;
        end else begin
          dq_r  <= dq_nxt;
          rem_r <= rem_nxt;
        end
      end
      S_DIVW: begin
        dq_r  <= dq_nxt;
        rem_r <= rem_nxt;
        if (div_cnt_r == 4'(DIV_BITS - 1)) wcol_r <= 10'(dq_nxt + 10'd1);
      end
      S_MUL: begin
        case (mstep_r)
          MS_PLANE:  plane_r <= 18'(mul_p);
          MS_CHAN:   cp1_r   <= 25'(mul_p);
          MS_ROWOFS: begin
            rh_r  <= 12'(mul_p);
            acc_r <= ADDR_W'(cp1_r - 25'(plane_r));
          end
          MS_COLOFS: rw_r <= 12'(mul_p);
          MS_ROWADR: begin
            rhw_r <= ADDR_W'(mul_p);
            acc_r <= acc_r + ADDR_W'(rw_r);
          end
          MS_PADADR: begin
            padw_r <= 12'(mul_p);
            acc_r  <= acc_r + rhw_r;
          end
          MS_CROW: begin
            crow_r <= 12'(mul_p);
            acc_r  <= acc_r - ADDR_W'(padw_r) - ADDR_W'(pad_r);
          end
          MS_AREA:   crow_r <= 12'(mul_p);
          MS_COLROW: colb_r <= mul_p;
          MS_COLPOS: colb_r <= mul_p;
          MS_STEP:   step_r <= 20'(mul_p);
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // Window walk: row-major over the kernel, column address steps by hcol*wcol
  always_ff @(posedge clk) begin
    if (state_r == S_SETUP) begin
      g_p_r    <= '0;
      g_j_r    <= '0;
      g_h_r    <= $signed(11'(rh_r) - 11'(pad_r));
      g_w_r    <= $signed(11'(rw_r) - 11'(pad_r));
      w0_r     <= $signed(11'(rw_r) - 11'(pad_r));
      g_row_r  <= acc_r;
      g_addr_r <= acc_r;
      g_col_r  <= colb_r + 28'(ocol_r);
    end else if (gen_go) begin
      g_col_r <= g_col_r + 28'(step_r);
      if (g_row_end) begin
        g_j_r    <= '0;
        g_p_r    <= g_p_r + KC_W'(1);
        g_h_r    <= g_h_r + 11'sd1;
        g_w_r    <= w0_r;
        g_row_r  <= g_row_r + ADDR_W'(in_width_r);
        g_addr_r <= g_row_r + ADDR_W'(in_width_r);
      end else begin
        g_j_r    <= g_j_r + KC_W'(1);
        g_w_r    <= g_w_r + 11'sd1;
        g_addr_r <= g_addr_r + ADDR_W'(1);
      end
    end

    if (gen_go) begin
      pend_pad_r  <= g_pad;
      pend_last_r <= g_last;
      pend_col_r  <= g_col_r;
      pend_addr_r <= g_addr_r;
    end
  end

  // Store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) mem[ADDR_W'(in_image_index)] <= in_pixel;
    mem_q <= mem[mem_raddr];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (move) begin
      out_tdata_r <= {4'd0, (pend_pad_r ? 32'd0 : mem_q), pend_col_r};
      out_tuser_r <= {ST_OK, pend_pad_r};
      out_tlast_r <= pend_last_r;
    end else if (err_load) begin
      out_tdata_r <= 64'd0;
      out_tuser_r <= {ST_ERR, 1'b0};
      out_tlast_r <= 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

  // Checks
  `IM2COL_ASSERT_IMP(a_ready_drained, in_tready, !gen_valid_r && !pend_valid_r, "ready with window in flight")
  `IM2COL_ASSERT_IMP(a_pad_zero, out_tvalid && out_tuser[0], out_tdata[59:28] == 32'd0, "padding value not zero")
  `IM2COL_ASSERT_IMP(a_err_form, out_tvalid && out_tuser[1], out_tlast && !out_tuser[0], "malformed error result")
  `IM2COL_ASSERT_NXT(a_emit_exit, (state_r == S_EMIT) && !gen_valid_r && !pend_valid_r, state_r == S_IDLE, "window walk did not finish")

endmodule
